/* rtl/core/mmfc_pkg.sv */
// Shared types, constants and constant tables for the multimode filter and clipper.
// Holds the microcode control word, the config record and the elaboration-time sine and
// gain tables. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mmfc_pkg;

    // Sine table depth, a power of two.
    localparam int SINE_DEPTH = 256;
    localparam int SINE_AW    = $clog2(SINE_DEPTH);

    localparam int ST_MAX     = 8388607;
    localparam int ST_MIN     = -8388608;
    localparam int SMP_MAX    = 131071;
    localparam int SMP_MIN    = -131072;
    localparam int ONE_Q14    = 16384;
    localparam int DAMP_Q16   = 117965;      // 1.8 in Q16
    localparam int INV2PI_Q32 = 683565276;   // 2^32 / (2*pi)

    localparam logic [2:0] FM_NONE    = 3'd0;
    localparam logic [2:0] FM_ONEPOLE = 3'd1;
    localparam logic [2:0] FM_RES     = 3'd2;
    localparam logic [2:0] FM_SVF_LP  = 3'd3;
    localparam logic [2:0] FM_SVF_HP  = 3'd4;
    localparam logic [2:0] FM_SVF_BP  = 3'd5;
    localparam logic [2:0] FM_SVF_BS  = 3'd6;

    localparam logic [1:0] CM_NONE = 2'd0;
    localparam logic [1:0] CM_HARD = 2'd1;
    localparam logic [1:0] CM_SINE = 2'd2;

    typedef struct packed {
        logic [2:0]  filter_mode;
        logic [1:0]  clip_mode;
        logic [15:0] cutoff;
        logic [15:0] resonance;
        logic [15:0] amp_limit;
        logic [7:0]  clip_boost;
    } t_cfg;

    // multiplier operand A (data side)
    typedef enum logic [3:0] {
        A_X, A_L, A_H, A_B, A_T, A_TMB, A_RC, A_Y, A_ALO, A_AHI
    } t_asel;

    // multiplier operand B (coefficient side)
    typedef enum logic [3:0] {
        B_C, B_CM, B_R, B_DAMP, B_D, B_GAIN, B_M, B_MLO, B_MHI, B_K
    } t_bsel;

    // ALU operation, works on the product of the previous step
    typedef enum logic [3:0] {
        OP_NOP, OP_LD, OP_OP1, OP_V, OP_RES, OP_D, OP_TL, OP_HS, OP_BS,
        OP_Y, OP_HARD, OP_AY, OP_P1, OP_AF, OP_PH
    } t_op;

    typedef struct packed {
        t_asel asel;
        t_bsel bsel;
        t_op   op;
    } t_ctl;

    localparam t_ctl CTL_NOP = '{asel: A_X, bsel: B_C, op: OP_NOP};

    typedef logic signed [15:0] t_sine_tab [SINE_DEPTH];
    typedef logic [23:0]        t_mtab [256];

    // floor((v + 2^15) / 2^16)
    function automatic logic signed [41:0] rnd16(input logic signed [57:0] v);
        return 42'((v + 58'sd32768) >>> 16);
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [41:0] v);
        logic signed [23:0] res;
        if (v > 42'(ST_MAX)) begin
            res = 24'(ST_MAX);
        end else if (v < 42'(ST_MIN)) begin
            res = 24'(ST_MIN);
        end else begin
            res = v[23:0];
        end
        return res;
    endfunction

    function automatic logic signed [17:0] sat18(input logic signed [41:0] v);
        logic signed [17:0] res;
        if (v > 42'(SMP_MAX)) begin
            res = 18'(SMP_MAX);
        end else if (v < 42'(SMP_MIN)) begin
            res = 18'(SMP_MIN);
        end else begin
            res = v[17:0];
        end
        return res;
    endfunction

    // Polynomial sine over one quarter, mirrored into a full turn, Q2.14.
    function automatic t_sine_tab build_sine();
        t_sine_tab   tab;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] rr;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] one;
        for (int k = 0; k < SINE_DEPTH; k++) begin
            one = 64'd1073741824;
            q   = (64'(4 * k)) / SINE_DEPTH;
            r   = 64'(4 * k) - q * SINE_DEPTH;
            rr  = q[0] ? (64'(SINE_DEPTH) - r) : r;
            x   = (rr * 64'd1686629713) / SINE_DEPTH;
            x2  = (x * x) >> 30;
            t   = one;
            t   = one - ((x2 * t) >> 30) / 110;
            t   = one - ((x2 * t) >> 30) / 72;
            t   = one - ((x2 * t) >> 30) / 42;
            t   = one - ((x2 * t) >> 30) / 20;
            t   = one - ((x2 * t) >> 30) / 6;
            s   = (((x * t) >> 30) + 64'd32768) >> 16;
            if (s > 64'(ONE_Q14)) begin
                s = 64'(ONE_Q14);
            end
            tab[k] = (q >= 64'd2) ? 16'(64'd0 - s) : 16'(s);
        end
        return tab;
    endfunction

    // Sine clipper gain 0.7*(1.3+boost) in Q16, one entry per boost value.
    function automatic t_mtab build_mtab();
        t_mtab       tab;
        logic [63:0] m;
        for (int b = 0; b < 256; b++) begin
            m      = (64'd65536 * (64'd91 + 64'd70 * 64'(b)) + 64'd50) / 100;
            tab[b] = 24'(m);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine();
    localparam t_mtab     MTAB     = build_mtab();

endpackage

`default_nettype wire

/* rtl/core/mmfc_cfg.sv */
// Configuration register file on an APB-style port.
// Depends on mmfc_pkg for the config record.
`timescale 1ns / 1ps
`default_nettype none

module mmfc_cfg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready,
    output mmfc_pkg::t_cfg     o_cfg
);
    import mmfc_pkg::*;

    localparam logic [2:0] REG_FILTER_MODE = 3'd0;
    localparam logic [2:0] REG_CLIP_MODE   = 3'd1;
    localparam logic [2:0] REG_CUTOFF      = 3'd2;
    localparam logic [2:0] REG_RESONANCE   = 3'd3;
    localparam logic [2:0] REG_AMP_LIMIT   = 3'd4;
    localparam logic [2:0] REG_CLIP_BOOST  = 3'd5;

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_FILTER_MODE: r_cfg.filter_mode <= pwdata[2:0];
                REG_CLIP_MODE:   r_cfg.clip_mode   <= pwdata[1:0];
                REG_CUTOFF:      r_cfg.cutoff      <= pwdata[15:0];
                REG_RESONANCE:   r_cfg.resonance   <= pwdata[15:0];
                REG_AMP_LIMIT:   r_cfg.amp_limit   <= pwdata[15:0];
                REG_CLIP_BOOST:  r_cfg.clip_boost  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FILTER_MODE: prdata = {29'd0, r_cfg.filter_mode};
            REG_CLIP_MODE:   prdata = {30'd0, r_cfg.clip_mode};
            REG_CUTOFF:      prdata = {16'd0, r_cfg.cutoff};
            REG_RESONANCE:   prdata = {16'd0, r_cfg.resonance};
            REG_AMP_LIMIT:   prdata = {16'd0, r_cfg.amp_limit};
            REG_CLIP_BOOST:  prdata = {24'd0, r_cfg.clip_boost};
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/mmfc_seq.sv */
// Microcode sequencer: control store, step counter and jump logic.
// Depends on mmfc_pkg for the control word and config record.
`timescale 1ns / 1ps
`default_nettype none

module mmfc_seq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic           i_out_free,
    input  wire mmfc_pkg::t_cfg i_cfg,
    output mmfc_pkg::t_ctl      o_ctl,
    output logic                o_busy,
    output logic                o_done
);
    import mmfc_pkg::*;

    typedef logic [4:0] t_uaddr;

    typedef enum logic [2:0] {J_NEXT, J_GOTO, J_BZ, J_CLIP, J_END} t_jmp;

    typedef struct packed {
        t_ctl   ctl;
        t_jmp   jmp;
        t_uaddr nxt;
    } t_uword;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} t_state;

    // program entry points
    localparam t_uaddr UA_Y     = 5'd0;
    localparam t_uaddr UA_OP1   = 5'd1;
    localparam t_uaddr UA_RES   = 5'd4;
    localparam t_uaddr UA_SVF   = 5'd9;
    localparam t_uaddr UA_HARD  = 5'd15;
    localparam t_uaddr UA_SINE  = 5'd17;
    localparam t_uaddr UA_PHASE = 5'd22;

    function automatic t_uword mk(input t_asel a, input t_bsel b, input t_op op,
                                  input t_jmp j, input t_uaddr n);
        t_uword w;
        w.ctl.asel = a;
        w.ctl.bsel = b;
        w.ctl.op   = op;
        w.jmp      = j;
        w.nxt      = n;
        return w;
    endfunction

    // Each step: issue A*B into the product register, and run the ALU op on the
    // product issued by the step before.
    function automatic t_uword ucode(input t_uaddr a);
        t_uword w;
        case (a)
            UA_Y:              w = mk(A_X,   B_C,    OP_Y,    J_CLIP, UA_Y);
            // one-pole lowpass
            UA_OP1:            w = mk(A_X,   B_C,    OP_NOP,  J_NEXT, UA_Y);
            UA_OP1 + 5'd1:     w = mk(A_L,   B_CM,   OP_LD,   J_NEXT, UA_Y);
            UA_OP1 + 5'd2:     w = mk(A_X,   B_C,    OP_OP1,  J_GOTO, UA_Y);
            // resonant two-tap lowpass
            UA_RES:            w = mk(A_X,   B_C,    OP_NOP,  J_NEXT, UA_Y);
            UA_RES + 5'd1:     w = mk(A_H,   B_CM,   OP_LD,   J_NEXT, UA_Y);
            UA_RES + 5'd2:     w = mk(A_X,   B_C,    OP_V,    J_NEXT, UA_Y);
            UA_RES + 5'd3:     w = mk(A_TMB, B_R,    OP_NOP,  J_NEXT, UA_Y);
            UA_RES + 5'd4:     w = mk(A_X,   B_C,    OP_RES,  J_GOTO, UA_Y);
            // state-variable filter
            UA_SVF:            w = mk(A_RC,  B_DAMP, OP_NOP,  J_NEXT, UA_Y);
            UA_SVF + 5'd1:     w = mk(A_B,   B_C,    OP_D,    J_NEXT, UA_Y);
            UA_SVF + 5'd2:     w = mk(A_B,   B_D,    OP_TL,   J_NEXT, UA_Y);
            UA_SVF + 5'd3:     w = mk(A_X,   B_C,    OP_HS,   J_NEXT, UA_Y);
            UA_SVF + 5'd4:     w = mk(A_H,   B_C,    OP_NOP,  J_NEXT, UA_Y);
            UA_SVF + 5'd5:     w = mk(A_X,   B_C,    OP_BS,   J_GOTO, UA_Y);
            // hard clipper
            UA_HARD:           w = mk(A_Y,   B_GAIN, OP_NOP,  J_NEXT, UA_Y);
            UA_HARD + 5'd1:    w = mk(A_X,   B_C,    OP_HARD, J_END,  UA_Y);
            // sine clipper, gain skipped when boost is zero
            UA_SINE:           w = mk(A_Y,   B_M,    OP_AY,   J_BZ,   UA_PHASE);
            UA_SINE + 5'd1:    w = mk(A_X,   B_C,    OP_P1,   J_NEXT, UA_Y);
            UA_SINE + 5'd2:    w = mk(A_T,   B_MLO,  OP_NOP,  J_NEXT, UA_Y);
            UA_SINE + 5'd3:    w = mk(A_T,   B_MHI,  OP_LD,   J_NEXT, UA_Y);
            UA_SINE + 5'd4:    w = mk(A_X,   B_C,    OP_AF,   J_NEXT, UA_Y);
            UA_PHASE:          w = mk(A_ALO, B_K,    OP_NOP,  J_NEXT, UA_Y);
            UA_PHASE + 5'd1:   w = mk(A_AHI, B_K,    OP_LD,   J_NEXT, UA_Y);
            UA_PHASE + 5'd2:   w = mk(A_X,   B_C,    OP_PH,   J_END,  UA_Y);
            default:           w = mk(A_X,   B_C,    OP_NOP,  J_END,  UA_Y);
        endcase
        return w;
    endfunction

    t_state r_state;
    t_state n_state;
    t_uaddr r_pc;
    t_uaddr n_pc;
    t_uword uw;

    assign uw     = ucode(r_pc);
    assign o_ctl  = (r_state == S_RUN) ? uw.ctl : CTL_NOP;
    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        o_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_RUN;
                    case (i_cfg.filter_mode) inside
                        FM_ONEPOLE:              n_pc = UA_OP1;
                        FM_RES:                  n_pc = UA_RES;
                        [FM_SVF_LP:FM_SVF_BS]:   n_pc = UA_SVF;
                        default:                 n_pc = UA_Y;
                    endcase
                end
            end
            S_RUN: begin
                case (uw.jmp)
                    J_NEXT: n_pc = r_pc + 5'd1;
                    J_GOTO: n_pc = uw.nxt;
                    J_BZ: begin
                        n_pc = (i_cfg.clip_boost == 8'd0) ? uw.nxt : r_pc + 5'd1;
                    end
                    J_CLIP: begin
                        case (i_cfg.clip_mode)
                            CM_HARD: n_pc = UA_HARD;
                            CM_SINE: n_pc = UA_SINE;
                            default: n_state = S_DONE;
                        endcase
                    end
                    J_END:   n_state = S_DONE;
                    default: n_state = S_DONE;
                endcase
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= UA_Y;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/mmfc_dp.sv */
// Datapath: one shared signed multiplier with a product register, the accumulator,
// the filter states and the clipper/sine-lookup logic. Depends on mmfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mmfc_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [17:0] i_sample,
    input  wire mmfc_pkg::t_ctl     i_ctl,
    input  wire mmfc_pkg::t_cfg     i_cfg,
    output logic signed [17:0]      o_y
);
    import mmfc_pkg::*;

    localparam logic [46:0] PH_HALF = 47'd1 << (45 - SINE_AW);

    logic signed [17:0] r_x;
    logic signed [23:0] r_l;
    logic signed [23:0] r_h;
    logic signed [23:0] r_b;
    logic signed [23:0] r_n;
    logic signed [26:0] r_t;
    logic        [16:0] r_d;
    logic signed [35:0] r_a;
    logic signed [17:0] r_y;
    logic signed [57:0] r_acc;
    logic signed [57:0] r_prod;

    logic signed [26:0] opa;
    logic signed [30:0] opb;
    logic        [16:0] cm;
    logic        [16:0] rc;
    logic        [9:0]  gain;
    logic        [23:0] m;

    logic signed [41:0] rp;
    logic signed [41:0] ra;
    logic signed [41:0] af;
    logic signed [23:0] res_v;
    logic signed [23:0] svf_b;
    logic signed [23:0] svf_l;
    logic signed [23:0] svf_n;
    logic signed [26:0] amp_p;
    logic signed [23:0] ysrc;
    logic signed [17:0] hard_y;
    logic        [45:0] frac;
    logic        [46:0] isum;
    logic [SINE_AW-1:0] idx;

    assign cm   = 17'h10000 - {1'b0, i_cfg.cutoff};
    assign rc   = 17'h10000 - {1'b0, i_cfg.resonance};
    assign gain = {({1'b0, i_cfg.clip_boost} + 9'd1), 1'b0};
    assign m    = MTAB[i_cfg.clip_boost];
    assign o_y  = r_y;

    always_comb begin
        case (i_ctl.asel)
            A_X:     opa = 27'(r_x);
            A_L:     opa = 27'(r_l);
            A_H:     opa = 27'(r_h);
            A_B:     opa = 27'(r_b);
            A_T:     opa = r_t;
            A_TMB:   opa = r_t - 27'(r_b);
            A_RC:    opa = $signed({10'd0, rc});
            A_Y:     opa = 27'(r_y);
            A_ALO:   opa = $signed({9'd0, r_a[17:0]});
            A_AHI:   opa = 27'($signed(r_a[35:18]));
            default: opa = '0;
        endcase
    end

    always_comb begin
        case (i_ctl.bsel)
            B_C:     opb = $signed({15'd0, i_cfg.cutoff});
            B_CM:    opb = $signed({14'd0, cm});
            B_R:     opb = $signed({15'd0, i_cfg.resonance});
            B_DAMP:  opb = 31'(DAMP_Q16);
            B_D:     opb = $signed({14'd0, r_d});
            B_GAIN:  opb = $signed({21'd0, gain});
            B_M:     opb = $signed({7'd0, m});
            B_MLO:   opb = $signed({19'd0, m[11:0]});
            B_MHI:   opb = $signed({19'd0, m[23:12]});
            B_K:     opb = 31'(INV2PI_Q32);
            default: opb = '0;
        endcase
    end

    assign rp = rnd16(r_prod);
    assign ra = rnd16(r_acc + r_prod);
    assign af = rnd16(r_acc + (r_prod <<< 12));

    assign res_v = sat24(42'(r_t) + rp);
    assign svf_b = sat24(42'(r_b) + rp);

    // low state clamped to +-amp_limit
    assign amp_p = $signed({11'd0, i_cfg.amp_limit});
    always_comb begin
        if (r_t > amp_p) begin
            svf_l = 24'(amp_p);
        end else if (r_t < -amp_p) begin
            svf_l = 24'(-amp_p);
        end else begin
            svf_l = 24'(r_t);
        end
    end
    assign svf_n = sat24(42'(svf_l) + 42'(r_h));

    always_comb begin
        case (i_cfg.filter_mode) inside
            FM_ONEPOLE, FM_RES, FM_SVF_LP: ysrc = r_l;
            FM_SVF_HP:                     ysrc = r_h;
            FM_SVF_BP:                     ysrc = r_b;
            FM_SVF_BS:                     ysrc = r_n;
            default:                       ysrc = 24'(r_x);
        endcase
    end

    always_comb begin
        if (r_prod > 58'(ONE_Q14)) begin
            hard_y = 18'(ONE_Q14);
        end else if (r_prod < -58'(ONE_Q14)) begin
            hard_y = -18'(ONE_Q14);
        end else begin
            hard_y = r_prod[17:0];
        end
    end

    // phase = a * 2^32/(2*pi) modulo one turn; the high part of a enters shifted
    assign frac = r_acc[45:0] + {r_prod[27:0], 18'd0};
    assign isum = {1'b0, frac} + PH_HALF;
    assign idx  = isum[45 -: SINE_AW];

    // filter state, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l <= '0;
            r_h <= '0;
            r_b <= '0;
            r_n <= '0;
        end else begin
            case (i_ctl.op)
                OP_OP1: r_l <= sat24(ra);
                OP_RES: begin
                    r_b <= r_h;
                    r_h <= res_v;
                    r_l <= res_v;
                end
                OP_HS:  r_h <= sat24(42'(r_x) - 42'(r_l) - rp);
                OP_BS: begin
                    r_b <= svf_b;
                    r_l <= svf_l;
                    r_n <= svf_n;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 58'(opa) * 58'(opb);
        if (i_start) begin
            r_x <= i_sample;
        end
        case (i_ctl.op)
            OP_LD:   r_acc <= r_prod;
            OP_V:    r_t   <= 27'(ra);
            OP_D:    r_d   <= rp[16:0];
            OP_TL:   r_t   <= 27'(42'(r_l) + rp);
            OP_Y:    r_y   <= sat18(42'(ysrc));
            OP_HARD: r_y   <= hard_y;
            OP_AY:   r_a   <= 36'(r_y);
            OP_P1:   r_t   <= 27'(rp);
            OP_AF:   r_a   <= 36'(af);
            OP_PH:   r_y   <= 18'(SINE_TAB[idx]);
            default: ;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/multimode_filter_and_clipper.sv */
// Multimode filter and clipper, Q4.14 audio samples in and out. One sample is in work at a
// time; a microcode program drives one shared 27x31 multiplier, one product per step, and
// the program length sets the rate. Filter steps are 1 (bypass), 4 (one-pole), 6 (resonant)
// or 7 (state-variable), and clip steps 0 (none), 2 (hard), 4 (sine, boost 0) or 8 (sine).
// The finished sample sits in an output register; the next sample is taken once it is
// loaded there. Configuration on the APB port should be written while no sample is in work.
// Depends on mmfc_pkg, mmfc_cfg, mmfc_seq, mmfc_dp.
`timescale 1ns / 1ps
`default_nettype none

module multimode_filter_and_clipper (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [23:0]   s_axis_tdata,   // [17:0] sample_in, [23:18] zero
    input  wire logic          s_axis_tlast,   // last_in
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic      [23:0]   m_axis_tdata,   // [17:0] sample_out, [23:18] zero
    output logic               m_axis_tlast,   // last_out
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready
);
    import mmfc_pkg::*;

    t_cfg               cfg;
    t_ctl               ctl;
    logic               busy;
    logic               done;
    logic               start;
    logic               out_free;
    logic signed [17:0] y;

    logic               r_last;
    logic               r_m_valid;
    logic signed [17:0] r_m_data;
    logic               r_m_last;

    assign s_axis_tready = ~busy;
    assign start         = s_axis_tvalid & ~busy;
    assign out_free      = ~r_m_valid | m_axis_tready;

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {6'd0, r_m_data};
    assign m_axis_tlast  = r_m_last;

    mmfc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mmfc_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_out_free (out_free),
        .i_cfg      (cfg),
        .o_ctl      (ctl),
        .o_busy     (busy),
        .o_done     (done)
    );

    mmfc_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_sample (s_axis_tdata[17:0]),
        .i_ctl    (ctl),
        .i_cfg    (cfg),
        .o_y      (y)
    );

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_last <= s_axis_tlast;
        end
        if (done) begin
            r_m_data <= y;
            r_m_last <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (done) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

/* bench/tb.sv */
// Self-checking bench for multimode_filter_and_clipper: streams Q4.14 samples through all
// filter and clip modes and checks every output against a cycle-free predictor.
// Depends on mmfc_pkg and the multimode_filter_and_clipper RTL.
`timescale 1ns / 1ps

module tb;
    import mmfc_pkg::*;

    // register indexes, byte address is 4*index
    localparam int REG_FILTER_MODE = 0;
    localparam int REG_CLIP_MODE   = 1;
    localparam int REG_CUTOFF      = 2;
    localparam int REG_RESONANCE   = 3;
    localparam int REG_AMP_LIMIT   = 4;
    localparam int REG_CLIP_BOOST  = 5;

    localparam logic [2:0] FM_UNUSED = 3'd7;
    localparam logic [1:0] CM_UNUSED = 2'd3;

    localparam longint DAMP_1P8    = 117965;      // 1.8 in Q16
    localparam longint TURN_SCALE  = 683565276;   // 2^32 / (2*pi)
    localparam longint HALF_PI_Q30 = 1686629713;
    localparam longint ONE_Q30     = 1073741824;
    localparam longint STATE_MAX   = 8388607;
    localparam longint STATE_MIN   = -8388608;
    localparam longint OUT_MAX     = 131071;
    localparam longint OUT_MIN     = -131072;
    localparam longint UNITY_Q14   = 16384;

    localparam logic signed [17:0] CORNER_SAMPLES [7] =
        '{18'sd0, 18'sd1, -18'sd1, 18'sd131071, -18'sd131072, 18'sd16384, -18'sd16384};

    typedef struct {
        logic signed [17:0] sample;
        logic               last;
    } t_sample_xact;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [23:0]   s_axis_tdata = '0;   // [17:0] sample_in, [23:18] zero
    logic          s_axis_tlast = 1'b0; // last_in
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [23:0]   m_axis_tdata;        // [17:0] sample_out, [23:18] zero
    logic          m_axis_tlast;        // last_out
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [4:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;

    multimode_filter_and_clipper u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // shadow of the block's registers and filter state
    t_cfg               cfg_shadow = '0;
    logic signed [23:0] low_st = '0;
    logic signed [23:0] high_st = '0;
    logic signed [23:0] band_st = '0;
    logic signed [23:0] notch_st = '0;
    logic signed [17:0] sine_lut [SINE_DEPTH];

    t_sample_xact       pending_samples[$];
    t_sample_xact       expected_samples[$];
    t_sample_xact       cur_item;
    logic signed [17:0] prev_sample = '0;

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_cnt = 0;
    logic hold_req = 1'b0;
    int   err_count = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("multimode_filter_and_clipper test failed");
        $finish;
    end

    // floor((v + 2^15) / 2^16)
    function automatic longint round_q16(input longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void build_sine_lut();
        longint unsigned q, r, rr, x, x2, t, s;
        longint unsigned divs [5] = '{110, 72, 42, 20, 6};
        for (int k = 0; k < SINE_DEPTH; k++) begin
            q  = (4 * k) / SINE_DEPTH;
            r  = 4 * k - q * SINE_DEPTH;
            rr = q[0] ? SINE_DEPTH - r : r;
            x  = rr * HALF_PI_Q30 / SINE_DEPTH;
            x2 = (x * x) >> 30;
            t  = ONE_Q30;
            for (int i = 0; i < 5; i++)
                t = ONE_Q30 - ((x2 * t) >> 30) / divs[i];
            s = (((x * t) >> 30) + 32768) >> 16;
            if (s > UNITY_Q14)
                s = UNITY_Q14;
            sine_lut[k] = (q >= 2) ? -18'(s) : 18'(s);
        end
    endfunction

    function automatic logic signed [17:0] sine_of_phase(input longint a);
        longint          ph;
        longint unsigned frac, idx;
        ph   = a * TURN_SCALE;
        frac = ph & 64'h0000_3FFF_FFFF_FFFF;   // one turn is 2^46
        idx  = (frac * SINE_DEPTH + (64'd1 << 45)) >> 46;
        if (idx >= SINE_DEPTH)
            idx = 0;
        return sine_lut[idx];
    endfunction

    // one sample through filter and clipper, updates the shadow state
    function automatic t_sample_xact filter_clip_predict(input t_sample_xact in_x);
        longint x, c, cm, r, y, v, d, t, amp, a, m, boost;
        longint lo, hi, bd, nt;
        t_sample_xact res;
        x     = in_x.sample;
        c     = cfg_shadow.cutoff;
        cm    = 65536 - c;
        r     = cfg_shadow.resonance;
        boost = cfg_shadow.clip_boost;
        lo    = low_st;
        hi    = high_st;
        bd    = band_st;
        nt    = notch_st;
        y     = x;
        case (cfg_shadow.filter_mode)
            FM_ONEPOLE: begin
                lo = clamp(round_q16(c * x + cm * lo), STATE_MIN, STATE_MAX);
                y  = lo;
            end
            FM_RES: begin
                v  = round_q16(c * x + cm * hi);
                v  = clamp(v + round_q16((v - bd) * r), STATE_MIN, STATE_MAX);
                bd = hi;
                hi = v;
                lo = v;
                y  = v;
            end
            FM_SVF_LP, FM_SVF_HP, FM_SVF_BP, FM_SVF_BS: begin
                amp = cfg_shadow.amp_limit;
                d   = round_q16(DAMP_1P8 * (65536 - r));
                t   = lo + round_q16(c * bd);
                hi  = clamp(x - lo - round_q16(d * bd), STATE_MIN, STATE_MAX);
                bd  = clamp(bd + round_q16(c * hi), STATE_MIN, STATE_MAX);
                lo  = clamp(t, -amp, amp);
                nt  = clamp(lo + hi, STATE_MIN, STATE_MAX);
                case (cfg_shadow.filter_mode)
                    FM_SVF_LP: y = lo;
                    FM_SVF_HP: y = hi;
                    FM_SVF_BP: y = bd;
                    default:   y = nt;
                endcase
            end
            default: ;
        endcase
        y = clamp(y, OUT_MIN, OUT_MAX);
        case (cfg_shadow.clip_mode)
            CM_HARD: y = clamp(y * 2 * (1 + boost), -UNITY_Q14, UNITY_Q14);
            CM_SINE: begin
                a = y;
                // gain 0.91 at zero boost is close enough to unity to be skipped
                if (boost != 0) begin
                    m = (65536 * (91 + 70 * boost) + 50) / 100;
                    a = round_q16(round_q16(y * m) * m);
                end
                y = sine_of_phase(a);
            end
            default: ;
        endcase
        low_st     = lo[23:0];
        high_st    = hi[23:0];
        band_st    = bd[23:0];
        notch_st   = nt[23:0];
        res.sample = y[17:0];
        res.last   = in_x.last;
        return res;
    endfunction

    // sender: feeds pending samples, predicts each accepted transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_samples.push_back(filter_clip_predict(cur_item));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cur_item      = pending_samples.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {6'b0, cur_item.sample};
                    s_axis_tlast  <= cur_item.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(input string field, input longint exp_v, input longint act_v);
        err_count++;
        if (err_count <= 10)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
    endtask

    // receiver: random back-pressure, checks each output transaction
    always @(posedge i_clk) begin
        t_sample_xact want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_samples.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%0t: output transaction with nothing expected, sample %0d",
                                 $time, $signed(m_axis_tdata[17:0]));
                end else begin
                    want = expected_samples.pop_front();
                    if (m_axis_tdata[17:0] !== want.sample)
                        report_mismatch("sample_out", want.sample,
                                        $signed(m_axis_tdata[17:0]));
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last_out", want.last, m_axis_tlast);
                end
            end
            m_axis_tready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off, so the block backs up and stalls its input
    always @(posedge i_clk) begin
        if (hold_req)
            hold_cnt <= 400;
        else if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
    end

    task automatic reg_write(input int idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(4 * idx);
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FILTER_MODE: cfg_shadow.filter_mode = val[2:0];
            REG_CLIP_MODE:   cfg_shadow.clip_mode   = val[1:0];
            REG_CUTOFF:      cfg_shadow.cutoff      = val[15:0];
            REG_RESONANCE:   cfg_shadow.resonance   = val[15:0];
            REG_AMP_LIMIT:   cfg_shadow.amp_limit   = val[15:0];
            REG_CLIP_BOOST:  cfg_shadow.clip_boost  = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_cfg(input logic [2:0] fm, input logic [1:0] cm, input logic [15:0] cut,
                           input logic [15:0] res, input logic [15:0] amp,
                           input logic [7:0] boost);
        reg_write(REG_FILTER_MODE, 32'(fm));
        reg_write(REG_CLIP_MODE, 32'(cm));
        reg_write(REG_CUTOFF, 32'(cut));
        reg_write(REG_RESONANCE, 32'(res));
        reg_write(REG_AMP_LIMIT, 32'(amp));
        reg_write(REG_CLIP_BOOST, 32'(boost));
    endtask

    // wait until every queued sample went in and every expected sample came out
    task automatic settle();
        @(negedge i_clk);
        while (pending_samples.size() != 0 || s_axis_tvalid || expected_samples.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic push(input logic signed [17:0] s, input logic l);
        t_sample_xact it;
        it.sample = s;
        it.last   = l;
        pending_samples.push_back(it);
        prev_sample = s;
    endtask

    task automatic push_random(input int n);
        logic signed [17:0] s;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0:          s = CORNER_SAMPLES[$urandom_range(0, 6)];
                1, 2, 3, 4: s = 18'($urandom());
                5, 6, 7:    s = 18'($urandom_range(0, 8191)) - 18'sd4096;
                default:    s = prev_sample;   // held input lets the filter settle
            endcase
            push(s, $urandom_range(0, 15) == 0);
        end
    endtask

    function automatic logic [15:0] pick_coeff();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [7:0] pick_boost();
        case ($urandom_range(0, 4))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd255;
            default: return 8'($urandom());
        endcase
    endfunction

    initial begin
        build_sine_lut();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // registers at reset: bypass, no clipping
        push(18'sd0, 1'b0);
        push(18'sd131071, 1'b0);
        push(-18'sd131072, 1'b1);
        push(-18'sd1, 1'b0);
        push(18'sd16384, 1'b1);
        settle();
        set_cfg(FM_ONEPOLE, CM_NONE, 16'hFFFF, 16'h0000, 16'h0000, 8'd0);
        push(18'sd131071, 1'b0);
        push(-18'sd131072, 1'b1);
        settle();
        set_cfg(FM_RES, CM_NONE, 16'd40000, 16'hFFFF, 16'h0000, 8'd0);
        push(18'sd131071, 1'b0);
        push(-18'sd131072, 1'b0);
        push(18'sd131071, 1'b1);
        settle();
        set_cfg(FM_SVF_LP, CM_NONE, 16'hFFFF, 16'h0000, 16'hFFFF, 8'd0);
        push(18'sd131071, 1'b0);
        push(-18'sd131072, 1'b0);
        settle();
        reg_write(REG_FILTER_MODE, 32'(FM_SVF_HP));
        push(18'sd131071, 1'b0);
        settle();
        reg_write(REG_FILTER_MODE, 32'(FM_SVF_BP));
        push(18'sd131071, 1'b0);
        settle();
        // zero amplitude limit pins the low state
        set_cfg(FM_SVF_BS, CM_NONE, 16'hFFFF, 16'hFFFF, 16'h0000, 8'd0);
        push(18'sd131071, 1'b1);
        settle();
        reg_write(REG_FILTER_MODE, 32'(FM_UNUSED));
        push(18'sd100, 1'b0);
        settle();
        set_cfg(FM_NONE, CM_HARD, 16'h0000, 16'h0000, 16'h0000, 8'd255);
        push(18'sd1, 1'b0);
        push(-18'sd1, 1'b1);
        settle();
        reg_write(REG_CLIP_MODE, 32'(CM_SINE));
        reg_write(REG_CLIP_BOOST, 32'd0);
        push(18'sd131071, 1'b0);
        settle();
        reg_write(REG_CLIP_BOOST, 32'd255);
        push(-18'sd131072, 1'b0);
        push(18'sd12345, 1'b1);
        settle();
        reg_write(REG_CLIP_MODE, 32'(CM_UNUSED));
        push(18'sd131071, 1'b0);

        for (int ph = 0; ph < 14; ph++) begin
            settle();
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            if (ph == 0)
                set_cfg(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                        16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255);
            else if (ph == 1)
                set_cfg(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                        16'h0000, 16'h0000, 16'h0000, 8'd0);
            else
                set_cfg(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                        pick_coeff(), pick_coeff(), pick_coeff(), pick_boost());
            push_random(50);
            if (ph == 4) begin
                @(posedge i_clk);
                hold_req <= 1'b1;
                @(posedge i_clk);
                hold_req <= 1'b0;
            end
        end

        settle();
        repeat (40) @(posedge i_clk);
        if (expected_samples.size() != 0) begin
            $display("%0d expected samples never came out", expected_samples.size());
            err_count++;
        end
        if (err_count == 0)
            $display("multimode_filter_and_clipper test passed");
        else
            $display("multimode_filter_and_clipper test failed");
        $finish;
    end

endmodule
